>>> src/inverse_distance_weighted_average_core_defines.svh
// Assertion macros shared by the inverse-distance weighted average core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef INVERSE_DISTANCE_WEIGHTED_AVERAGE_CORE_DEFINES_SVH
`define INVERSE_DISTANCE_WEIGHTED_AVERAGE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define IDWA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IDWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDWA_ASSERT(lbl, clk, rst, prop, msg)
`define IDWA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> src/idwa_pkg.sv
// Types and constants of the inverse-distance weighted average core.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package idwa_pkg;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [15:0]        intensity;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [15:0] gain;
    logic        coincident;
    logic        overflow;
  } result_t;

  // Queue entry: the point plus the front's classification.
  typedef struct packed {
    point_t item;
    logic   ignore;
  } entry_t;

  typedef struct packed {
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
    logic signed [15:0] query_z;
  } query_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam int unsigned AddrW = 4;
  localparam logic [1:0] REG_QUERY_X = 2'd0;
  localparam logic [1:0] REG_QUERY_Y = 2'd1;
  localparam logic [1:0] REG_QUERY_Z = 2'd2;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_DIF  = 11'b00000000010,
    ST_SQ   = 11'b00000000100,
    ST_SUM  = 11'b00000001000,
    ST_CLS  = 11'b00000010000,
    ST_DIV  = 11'b00000100000,
    ST_MAC  = 11'b00001000000,
    ST_ACC  = 11'b00010000000,
    ST_END  = 11'b00100000000,
    ST_FDIV = 11'b01000000000,
    ST_OUT  = 11'b10000000000
  } state_t;

endpackage
`default_nettype wire

>>> src/idwa_queue.sv
// Two-entry queue between the front and the back of the core.
// Depends on idwa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idwa_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  wire idwa_pkg::entry_t  wdata,
  input  wire                    pop,
  output idwa_pkg::entry_t       rdata,
  output idwa_pkg::qstat_t       stat
);
  idwa_pkg::entry_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  assign rdata      = mem[rptr];
  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);
endmodule
`default_nettype wire

>>> src/idwa_front.sv
// Front of the core: accepts points, counts them per cloud, marks ignored ones.
// Depends on idwa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idwa_front #(
  parameter int unsigned MAX_POINTS = 65536
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    point_valid,
  output logic                   point_ready,
  input  wire idwa_pkg::point_t  point_data,
  input  wire idwa_pkg::qstat_t  stat,
  output logic                   push,
  output idwa_pkg::entry_t       entry
);
  localparam int unsigned CW = $clog2(MAX_POINTS + 2);

  logic [CW-1:0] count;
  logic          ignore;

  assign ignore      = (count >= CW'(MAX_POINTS));
  assign point_ready = ~stat.full;
  assign push        = point_valid & point_ready;
  assign entry.item  = point_data;
  assign entry.ignore = ignore;

  // The count saturates one past the limit so overflow is remembered.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (point_data.last_point) begin
        count <= '0;
      end else if (ignore) begin
        count <= CW'(MAX_POINTS + 1);
      end else begin
        count <= count + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> src/idwa_back.sv
// Back of the core: distance, iterative reciprocal, accumulation, final divide.
// Depends on idwa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "inverse_distance_weighted_average_core_defines.svh"
module idwa_back #(
  parameter int unsigned MAX_POINTS        = 65536,
  parameter int unsigned WEIGHT_SCALE_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire idwa_pkg::query_t  query,
  input  wire idwa_pkg::qstat_t  stat,
  input  wire idwa_pkg::entry_t  entry,
  output logic                   pop,
  output logic                   result_valid,
  input  wire                    result_ready,
  output idwa_pkg::result_t      result_data
);
  localparam int unsigned W   = WEIGHT_SCALE_BITS;
  localparam int unsigned WS  = W + $clog2(MAX_POINTS);
  localparam int unsigned WIS = WS + 16;
  localparam int unsigned D2W = 34;
  localparam int unsigned DCW = $clog2(W + 2);

  idwa_pkg::state_t state;
  idwa_pkg::entry_t cur;
  logic [15:0]      ax, ay, az;
  logic [31:0]      sx, sy, sz;
  logic [D2W-1:0]   d2;
  logic [D2W-1:0]   rem;
  logic [W:0]       quo;
  logic [DCW-1:0]   dcnt;
  logic [W-1:0]     wgt;
  logic [W+15:0]    prod;
  logic [WS-1:0]    wsum;
  logic [WIS-1:0]   wisum;
  logic             hit;
  logic [15:0]      hit_int;
  logic [WS-1:0]    frem;
  logic [15:0]      fnum;
  logic [3:0]       fcnt;
  logic             load;

  logic signed [16:0] dx, dy, dz;
  logic [D2W:0]       trial;
  logic               ge;
  logic [WS:0]        ftrial;
  logic               fge;
  logic               out_stall;
  logic               in_out;
  logic               div_last;

  assign dx = 17'(cur.item.point_x) - 17'(query.query_x);
  assign dy = 17'(cur.item.point_y) - 17'(query.query_y);
  assign dz = 17'(cur.item.point_z) - 17'(query.query_z);

  assign trial  = {rem, (dcnt == DCW'(W))};
  assign ge     = (trial >= {1'b0, d2});
  assign ftrial = {frem, fnum[15]};
  assign fge    = (ftrial >= {1'b0, wsum});

  assign pop  = (state == idwa_pkg::ST_IDLE) & ~stat.empty;
  assign load = (state == idwa_pkg::ST_OUT) & (~result_valid | result_ready);

  assign in_out    = (state == idwa_pkg::ST_OUT);
  assign out_stall = in_out & result_valid & ~result_ready;
  assign div_last  = (state == idwa_pkg::ST_DIV) & (dcnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= idwa_pkg::ST_IDLE;
      wsum         <= '0;
      wisum        <= '0;
      hit          <= 1'b0;
      hit_int      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid & result_ready & ~load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        idwa_pkg::ST_IDLE: begin
          if (pop) begin
            cur   <= entry;
            state <= entry.ignore ? idwa_pkg::ST_END : idwa_pkg::ST_DIF;
          end
        end
        idwa_pkg::ST_DIF: begin
          ax    <= dx[16] ? 16'(-dx) : dx[15:0];
          ay    <= dy[16] ? 16'(-dy) : dy[15:0];
          az    <= dz[16] ? 16'(-dz) : dz[15:0];
          state <= idwa_pkg::ST_SQ;
        end
        idwa_pkg::ST_SQ: begin
          sx    <= ax * ax;
          sy    <= ay * ay;
          sz    <= az * az;
          state <= idwa_pkg::ST_SUM;
        end
        idwa_pkg::ST_SUM: begin
          d2    <= D2W'(sx) + D2W'(sy) + D2W'(sz);
          state <= idwa_pkg::ST_CLS;
        end
        idwa_pkg::ST_CLS: begin
          if (d2 == '0) begin
            if (!hit) begin
              hit     <= 1'b1;
              hit_int <= cur.item.intensity;
            end
            state <= idwa_pkg::ST_END;
          end else begin
            rem   <= '0;
            quo   <= '0;
            dcnt  <= DCW'(W);
            state <= idwa_pkg::ST_DIV;
          end
        end
        idwa_pkg::ST_DIV: begin
          // One quotient bit per cycle of 2^W / d2.
          rem <= ge ? D2W'(trial - {1'b0, d2}) : trial[D2W-1:0];
          quo <= {quo[W-1:0], ge};
          if (dcnt == '0) begin
            state <= idwa_pkg::ST_MAC;
          end else begin
            dcnt <= dcnt - 1'b1;
          end
        end
        idwa_pkg::ST_MAC: begin
          // A distance of one gives 2^W, which saturates to all ones.
          wgt   <= quo[W] ? {W{1'b1}} : quo[W-1:0];
          prod  <= (quo[W] ? {W{1'b1}} : quo[W-1:0]) * cur.item.intensity;
          state <= idwa_pkg::ST_ACC;
        end
        idwa_pkg::ST_ACC: begin
          wsum  <= wsum + WS'(wgt);
          wisum <= wisum + WIS'(prod);
          state <= idwa_pkg::ST_END;
        end
        idwa_pkg::ST_END: begin
          if (!cur.item.last_point) begin
            state <= idwa_pkg::ST_IDLE;
          end else if (hit || wsum == '0) begin
            fnum  <= hit ? hit_int : 16'd0;
            state <= idwa_pkg::ST_OUT;
          end else begin
            // The average is below 2^16, so the upper part is already a remainder.
            frem  <= wisum[WIS-1:16];
            fnum  <= wisum[15:0];
            fcnt  <= 4'd15;
            state <= idwa_pkg::ST_FDIV;
          end
        end
        idwa_pkg::ST_FDIV: begin
          frem <= fge ? WS'(ftrial - {1'b0, wsum}) : ftrial[WS-1:0];
          fnum <= {fnum[14:0], fge};
          if (fcnt == '0) begin
            state <= idwa_pkg::ST_OUT;
          end else begin
            fcnt <= fcnt - 1'b1;
          end
        end
        idwa_pkg::ST_OUT: begin
          if (load) begin
            result_valid           <= 1'b1;
            result_data.gain       <= fnum;
            result_data.coincident <= hit;
            result_data.overflow   <= cur.ignore;
            wsum                   <= '0;
            wisum                  <= '0;
            hit                    <= 1'b0;
            hit_int                <= '0;
            state                  <= idwa_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= idwa_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `IDWA_ASSERT(a_out_waits, clk, rst, out_stall |=> in_out, "result overwritten while pending")
  `IDWA_ASSERT(a_clear_after, clk, rst, load |=> (wsum == '0 && wisum == '0 && !hit), "sums kept")
  `IDWA_ASSERT(a_div_done, clk, rst, div_last |=> (state == idwa_pkg::ST_MAC), "divide overran")
endmodule
`default_nettype wire

>>> src/inverse_distance_weighted_average_core.sv
// Inverse-distance weighted average core: the back takes one point at a time through
// difference, square, sum, classify, the bit-serial reciprocal 2^W / d2
// (W = WEIGHT_SCALE_BITS, 32 by default), multiply and accumulate; a two-entry queue
// decouples the input. After the last point of a cloud the result is loaded directly
// when the cloud hit the query or has no weight, else after a 16-bit serial divide.
// Reset (rst, synchronous, active high) clears query registers, sums, count and queue.
`timescale 1ns / 1ps
`default_nettype none
module inverse_distance_weighted_average_core #(
  parameter int unsigned MAX_POINTS        = 65536,
  parameter int unsigned WEIGHT_SCALE_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [idwa_pkg::AddrW-1:0]    paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  wire                          point_valid,
  output logic                         point_ready,
  input  wire idwa_pkg::point_t        point_data,
  output logic                         result_valid,
  input  wire                          result_ready,
  output idwa_pkg::result_t            result_data
);
  // The query position lives here; the back reads it while it works on a point.
  // Writes must only happen while the core is idle; the core does not enforce it. No shadow copy is kept.
  idwa_pkg::query_t query;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        idwa_pkg::REG_QUERY_X: query.query_x <= pwdata[15:0];
        idwa_pkg::REG_QUERY_Y: query.query_y <= pwdata[15:0];
        idwa_pkg::REG_QUERY_Z: query.query_z <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read data is the raw 16-bit register, zero extended.
  always_comb begin
    unique case (reg_idx)
      idwa_pkg::REG_QUERY_X: prdata = {16'd0, query.query_x};
      idwa_pkg::REG_QUERY_Y: prdata = {16'd0, query.query_y};
      idwa_pkg::REG_QUERY_Z: prdata = {16'd0, query.query_z};
      default:               prdata = 32'd0;
    endcase
  end

  // The front takes a transaction whenever the queue has room and tags points
  // past the per-cloud limit; the back drains the queue one point at a time.
  idwa_pkg::qstat_t stat;
  idwa_pkg::entry_t wentry;
  idwa_pkg::entry_t rentry;
  logic             push;
  logic             pop;

  idwa_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .point_data (point_data),
    .stat       (stat),
    .push       (push),
    .entry      (wentry)
  );

  idwa_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(wentry),
    .pop  (pop),
    .rdata(rentry),
    .stat (stat)
  );

  // The back owns the result register; a pending result holds the back, and
  // the front stops taking new points into the queue once the queue is full.
  idwa_back #(
    .MAX_POINTS       (MAX_POINTS),
    .WEIGHT_SCALE_BITS(WEIGHT_SCALE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .query       (query),
    .stat        (stat),
    .entry       (rentry),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );
endmodule
`default_nettype wire
